FILE: rtl/psu_pkg.sv
`timescale 1ns / 1ps

package psu_pkg;

	localparam int BYTE_W = 8;
	localparam int LINE_CFG_W = 14;
	localparam int PIX_CFG_W = 4;
	localparam int CFG_DATA_W = 14;
	localparam int REG_IDX_W = 1;

	// Configuration register indexes.
	localparam logic [REG_IDX_W-1:0] REG_LINE_BYTES = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_PIXEL_BYTES = 1'd1;

	// Row filter types. Anything above FILT_PAETH behaves as FILT_NONE.
	localparam logic [BYTE_W-1:0] FILT_NONE = 8'd0;
	localparam logic [BYTE_W-1:0] FILT_SUB = 8'd1;
	localparam logic [BYTE_W-1:0] FILT_UP = 8'd2;
	localparam logic [BYTE_W-1:0] FILT_AVERAGE = 8'd3;
	localparam logic [BYTE_W-1:0] FILT_PAETH = 8'd4;

	// Control carried from the input register into the reconstruction stage.
	typedef struct packed {
		logic              is_filter;
		logic [BYTE_W-1:0] ftype;
		logic              a_valid;
		logic              first_row;
		logic              last;
		logic [BYTE_W-1:0] data;
	} psu_ctl_t;

	// Paeth predictor: the neighbor closest to a + b - c, ties to a, then b.
	function automatic logic [BYTE_W-1:0] paeth_pick(
		input logic [BYTE_W-1:0] a,
		input logic [BYTE_W-1:0] b,
		input logic [BYTE_W-1:0] c
	);
		logic signed [10:0] p;
		logic signed [10:0] da;
		logic signed [10:0] db;
		logic signed [10:0] dc;
		p = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({3'b000, c});
		da = p - $signed({3'b000, a});
		db = p - $signed({3'b000, b});
		dc = p - $signed({3'b000, c});
		if (da < 0) da = -da;
		if (db < 0) db = -db;
		if (dc < 0) dc = -dc;
		if (da <= db && da <= dc) begin
			return a;
		end else if (db <= dc) begin
			return b;
		end
		return c;
	endfunction

endpackage

FILE: rtl/psu_ifs.sv
`timescale 1ns / 1ps

interface psu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_of_image;

	modport source (output valid, output data_byte, output start_of_image, input ready);
	modport sink (input valid, input data_byte, input start_of_image, output ready);
endinterface

interface psu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_byte;
	logic       end_of_row;

	modport source (output valid, output pixel_byte, output end_of_row, input ready);
	modport sink (input valid, input pixel_byte, input end_of_row, output ready);
endinterface

FILE: rtl/psu_ram.sv
`timescale 1ns / 1ps

module psu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/psu_recon.sv
`timescale 1ns / 1ps

module psu_recon #(
	parameter int MAX_PIXEL_BYTES = 8,
	parameter int PW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    fire,
	input  psu_pkg::psu_ctl_t       ctl,
	input  logic [PW-1:0]           bpp_idx,
	input  logic [psu_pkg::BYTE_W-1:0] up_byte,
	output logic [psu_pkg::BYTE_W-1:0] res
);
	import psu_pkg::*;

	// Entry k holds the byte k+1 places back, in the current and previous row.
	logic [BYTE_W-1:0] left_q [MAX_PIXEL_BYTES];
	logic [BYTE_W-1:0] upleft_q [MAX_PIXEL_BYTES];

	logic [BYTE_W-1:0] a;
	logic [BYTE_W-1:0] b;
	logic [BYTE_W-1:0] c;
	logic [BYTE_W:0]   avg_sum;
	logic [BYTE_W-1:0] pred;

	always_comb begin
		a = ctl.a_valid ? left_q[bpp_idx] : '0;
		c = ctl.a_valid ? upleft_q[bpp_idx] : '0;
		b = ctl.first_row ? '0 : up_byte;
		avg_sum = {1'b0, a} + {1'b0, b};
		case (ctl.ftype)
			FILT_SUB:     pred = a;
			FILT_UP:      pred = b;
			FILT_AVERAGE: pred = avg_sum[BYTE_W:1];
			FILT_PAETH:   pred = paeth_pick(a, b, c);
			default:      pred = '0;
		endcase
		res = ctl.data + pred;
	end

	// A filter byte starts a row with empty neighbor history.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
				left_q[i] <= '0;
				upleft_q[i] <= '0;
			end
		end else if (fire) begin
			if (ctl.is_filter) begin
				for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
					left_q[i] <= '0;
					upleft_q[i] <= '0;
				end
			end else begin
				for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
					left_q[i] <= left_q[i-1];
					upleft_q[i] <= upleft_q[i-1];
				end
				left_q[0] <= res;
				upleft_q[0] <= b;
			end
		end
	end

endmodule

FILE: rtl/png_scanline_unfilter.sv
`timescale 1ns / 1ps

// PNG scanline unfilter. Inflated bytes enter on in_byte, one per beat; the
// first byte of each row is its filter type and the next line_bytes bytes are
// filtered data. Each data byte yields one reconstructed beat on out_byte,
// with end_of_row set on the last byte of the row; filter bytes yield nothing.
// A beat with start_of_image set always starts a new first row, whose upper
// neighbors read as zero.
// An input beat travels to the output beat through the input register
// (which also receives the previous-row byte from the line RAM) and then the
// result register. One beat is taken every cycle as long as the output side
// takes results; the throughput is set by the single-port-per-direction line
// RAM, which is read once when a byte enters and written once when it leaves
// the reconstruction stage.
// When out_byte stalls, the result register holds its beat and a data byte
// waiting in the input register stays there, so in_byte.ready drops; a filter
// byte still moves on since it produces no result.
// Reset clears the row position, makes the next row a first row, selects
// line_bytes = 1 and pixel_bytes = 1, and empties both stages. The line RAM is
// not cleared. Configuration writes (cfg_we, cfg_index, cfg_data) are meant
// for idle periods; out-of-range values are clamped to the supported range.
module png_scanline_unfilter #(
	parameter int MAX_LINE_BYTES = 8192,
	parameter int MAX_PIXEL_BYTES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	psu_in_if.sink                        in_byte,
	psu_out_if.source                     out_byte,
	input  logic                          cfg_we,
	input  logic [psu_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [psu_pkg::CFG_DATA_W-1:0] cfg_data
);
	import psu_pkg::*;

	localparam int AW = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;
	localparam int LEN_W = $clog2(MAX_LINE_BYTES + 1);
	localparam int CMP_W = (LEN_W > LINE_CFG_W) ? LEN_W : LINE_CFG_W;
	localparam int PW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
	localparam int PB_W = (PIX_CFG_W > PW + 1) ? PIX_CFG_W : PW + 1;
	localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_LINE_BYTES);
	localparam logic [PIX_CFG_W-1:0] MAX_PB = PIX_CFG_W'(MAX_PIXEL_BYTES);

	// Configuration registers.
	logic [LINE_CFG_W-1:0] line_bytes_q;
	logic [PIX_CFG_W-1:0]  pixel_bytes_q;

	// Row sequencing state.
	logic              expect_filter_q;
	logic              first_row_q;
	logic [AW-1:0]     col_q;
	logic [BYTE_W-1:0] ftype_q;

	// Input register stage.
	logic          s1_valid;
	psu_ctl_t      ctl_s1;
	logic [AW-1:0] col_s1;
	logic [PW-1:0] bpp_idx_s1;

	// Result register.
	logic              out_valid_q;
	logic [BYTE_W-1:0] pixel_q;
	logic              eor_q;

	logic              in_accept;
	logic              take_filter;
	logic              s1_fire;
	logic              out_free;
	logic [CMP_W-1:0]  lb_ext;
	logic [LEN_W-1:0]  len;
	logic [LEN_W-1:0]  col_ext;
	logic [LEN_W-1:0]  col_c;
	logic [AW-1:0]     col_addr;
	logic              last;
	logic [PIX_CFG_W-1:0] bpp;
	logic [PW-1:0]     bpp_idx;
	logic              a_valid;
	psu_ctl_t          ctl_next;
	logic [BYTE_W-1:0] up_byte;
	logic [BYTE_W-1:0] res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_bytes_q <= LINE_CFG_W'(1);
			pixel_bytes_q <= PIX_CFG_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LINE_BYTES:  line_bytes_q <= cfg_data[LINE_CFG_W-1:0];
				REG_PIXEL_BYTES: pixel_bytes_q <= cfg_data[PIX_CFG_W-1:0];
				default:         ;
			endcase
		end
	end

	// Effective row length and stride after clamping, and the column of the
	// incoming byte. A row shortened mid-way ends on the clamped last column.
	always_comb begin
		lb_ext = CMP_W'(line_bytes_q);
		if (lb_ext == '0) begin
			len = LEN_W'(1);
		end else if (lb_ext > MAX_LEN) begin
			len = MAX_LEN[LEN_W-1:0];
		end else begin
			len = lb_ext[LEN_W-1:0];
		end
		col_ext = LEN_W'(col_q);
		col_c = (col_ext >= len) ? len - LEN_W'(1) : col_ext;
		col_addr = col_c[AW-1:0];
		last = (col_c + LEN_W'(1)) == len;

		if (pixel_bytes_q == '0) begin
			bpp = PIX_CFG_W'(1);
		end else if (pixel_bytes_q > MAX_PB) begin
			bpp = MAX_PB;
		end else begin
			bpp = pixel_bytes_q;
		end
		bpp_idx = PW'(PB_W'(bpp) - PB_W'(1));
		a_valid = (col_c >= LEN_W'(bpp));
	end

	assign take_filter = in_byte.start_of_image || expect_filter_q;
	assign out_free = !out_valid_q || out_byte.ready;
	assign s1_fire = s1_valid && (ctl_s1.is_filter || out_free);
	assign in_byte.ready = !s1_valid || s1_fire;
	assign in_accept = in_byte.valid && in_byte.ready;

	always_comb begin
		ctl_next.is_filter = take_filter;
		ctl_next.ftype = ftype_q;
		ctl_next.a_valid = a_valid;
		ctl_next.first_row = first_row_q;
		ctl_next.last = last;
		ctl_next.data = in_byte.data_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_filter_q <= 1'b1;
			first_row_q <= 1'b1;
			col_q <= '0;
			ftype_q <= FILT_NONE;
		end else if (in_accept) begin
			if (take_filter) begin
				ftype_q <= in_byte.data_byte;
				expect_filter_q <= 1'b0;
				col_q <= '0;
				if (in_byte.start_of_image) begin
					first_row_q <= 1'b1;
				end
			end else if (last) begin
				expect_filter_q <= 1'b1;
				first_row_q <= 1'b0;
				col_q <= '0;
			end else begin
				col_q <= col_addr + AW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_accept) begin
			s1_valid <= 1'b1;
		end else if (s1_fire) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			ctl_s1 <= ctl_next;
			col_s1 <= col_addr;
			bpp_idx_s1 <= bpp_idx;
		end
	end

	// Previous-row line buffer: read as a data byte enters, written with the
	// reconstructed byte as it leaves.
	psu_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(MAX_LINE_BYTES),
		.AW   (AW)
	) u_line_ram (
		.clk  (clk),
		.we   (s1_fire && !ctl_s1.is_filter),
		.waddr(col_s1),
		.wdata(res),
		.re   (in_accept && !take_filter),
		.raddr(col_addr),
		.rdata(up_byte)
	);

	psu_recon #(
		.MAX_PIXEL_BYTES(MAX_PIXEL_BYTES),
		.PW             (PW)
	) u_recon (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (s1_fire),
		.ctl    (ctl_s1),
		.bpp_idx(bpp_idx_s1),
		.up_byte(up_byte),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && !ctl_s1.is_filter) begin
			out_valid_q <= 1'b1;
		end else if (out_byte.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && !ctl_s1.is_filter) begin
			pixel_q <= res;
			eor_q <= ctl_s1.last;
		end
	end

	assign out_byte.valid = out_valid_q;
	assign out_byte.pixel_byte = pixel_q;
	assign out_byte.end_of_row = eor_q;

	// A data byte held in the input register must block the input side.
	a_s1_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !s1_fire |-> !in_byte.ready)
		else $error("input accepted while the input register is held");

	// The last data byte of a row makes the next byte a filter byte.
	a_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && !take_filter && last |=> expect_filter_q && !first_row_q)
		else $error("row end did not rearm the filter byte");

	// A start of image always leads to a first row.
	a_soi_first: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && in_byte.start_of_image |=> first_row_q && !expect_filter_q)
		else $error("start of image did not start a first row");

	// Each data byte leaving the reconstruction stage lands in the result register.
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && !ctl_s1.is_filter |=> out_valid_q && pixel_q == $past(res))
		else $error("reconstructed byte was not registered");

endmodule
